// ----- rtl/crrs_pkg.sv -----
// Shared types and constants of the RRIP/SHiP replacement policy block.
`default_nettype none

package crrs_pkg;

    localparam int SET_IN_W  = 11;
    localparam int WAY_IN_W  = 4;
    localparam int SIG_IN_W  = 6;
    localparam int RND_W     = 5;
    localparam int WAY_OUT_W = 4;
    localparam int AGE_W     = 2;
    localparam int CTR_W     = 2;
    localparam int Q_DEPTH   = 2;

    typedef logic [AGE_W-1:0] age_t;
    typedef logic [CTR_W-1:0] ctr_t;

    localparam age_t AGE_HIT  = 2'd0;
    localparam age_t AGE_LONG = 2'd2;
    localparam age_t AGE_MAX  = 2'd3;

    localparam ctr_t REUSE_INIT = 2'd1;
    localparam ctr_t REUSE_MAX  = 2'd3;
    localparam ctr_t REUSE_DEAD = 2'd0;

    typedef enum logic [1:0] {
        LEAD_NONE,
        LEAD_SRRIP,
        LEAD_BRRIP
    } lead_kind_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_READ,
        ST_WRITE
    } back_state_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// ----- rtl/crrs_if.sv -----
// Valid/ready channel interfaces for access requests and policy results.
`default_nettype none

interface crrs_req_if;
    import crrs_pkg::*;

    logic                valid;
    logic                ready;
    logic [SET_IN_W-1:0] set_index;
    logic                hit;
    logic [WAY_IN_W-1:0] hit_way;
    logic [SIG_IN_W-1:0] signature;
    logic [RND_W-1:0]    random_bits;

    modport source (
        output valid, set_index, hit, hit_way, signature, random_bits,
        input  ready
    );

    modport sink (
        input  valid, set_index, hit, hit_way, signature, random_bits,
        output ready
    );
endinterface

interface crrs_rsp_if;
    import crrs_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WAY_OUT_W-1:0] chosen_way;
    logic [AGE_W-1:0]     inserted_age;
    logic                 used_bimodal;

    modport source (
        output valid, chosen_way, inserted_age, used_bimodal,
        input  ready
    );

    modport sink (
        input  valid, chosen_way, inserted_age, used_bimodal,
        output ready
    );
endinterface

`default_nettype wire

// ----- rtl/crrs_front.sv -----
// Front end: accepts accesses, reduces the fields and classifies the set as leader or follower.
`default_nettype none

module crrs_front #(
    parameter int NUM_SETS     = 2048,
    parameter int NUM_WAYS     = 16,
    parameter int SIG_WIDTH    = 6,
    parameter int LEADER_COUNT = 64,
    localparam int SET_W       = $clog2(NUM_SETS),
    localparam int WAY_W       = $clog2(NUM_WAYS),
    localparam int ENTRY_W     = SET_W + 1 + WAY_W + SIG_WIDTH + crrs_pkg::RND_W
                                 + $bits(crrs_pkg::lead_kind_t)
) (
    crrs_req_if.sink             req,
    input  logic                 clearing,
    input  crrs_pkg::q_stat_t    qstat,
    output logic                 push,
    output logic [ENTRY_W-1:0]   push_data
);
    import crrs_pkg::*;

    typedef struct packed {
        logic [SET_W-1:0]     set_idx;
        logic                 hit;
        logic [WAY_W-1:0]     way;
        logic [SIG_WIDTH-1:0] sig;
        logic [RND_W-1:0]     rnd;
        lead_kind_t           kind;
    } entry_t;

    localparam int BRRIP_LO = NUM_SETS - LEADER_COUNT;

    entry_t              ent;
    logic [SET_IN_W-1:0] set_rem;
    logic [WAY_IN_W-1:0] way_rem;

    // Both remainders are taken by a few conditional subtractions of scaled moduli.
    always_comb
    begin
        set_rem = req.set_index;
        for (int k = 3; k >= 0; k--)
        begin
            if ((NUM_SETS << k) < (1 << SET_IN_W))
            begin
                if (set_rem >= SET_IN_W'(NUM_SETS << k))
                begin
                    set_rem = set_rem - SET_IN_W'(NUM_SETS << k);
                end
            end
        end
        way_rem = req.hit_way;
        for (int k = 2; k >= 0; k--)
        begin
            if ((NUM_WAYS << k) < (1 << WAY_IN_W))
            begin
                if (way_rem >= WAY_IN_W'(NUM_WAYS << k))
                begin
                    way_rem = way_rem - WAY_IN_W'(NUM_WAYS << k);
                end
            end
        end
    end

    always_comb
    begin
        ent.set_idx = SET_W'(set_rem);
        ent.hit     = req.hit;
        ent.way     = WAY_W'(way_rem);
        ent.sig     = SIG_WIDTH'(req.signature);
        ent.rnd     = req.random_bits;
        if (int'(ent.set_idx) >= BRRIP_LO)
        begin
            ent.kind = LEAD_BRRIP;
        end
        else if (int'(ent.set_idx) < LEADER_COUNT)
        begin
            ent.kind = LEAD_SRRIP;
        end
        else
        begin
            ent.kind = LEAD_NONE;
        end
    end

    assign req.ready = !qstat.full && !clearing;
    assign push      = req.valid && req.ready;
    assign push_data = ent;

endmodule

`default_nettype wire

// ----- rtl/crrs_fifo.sv -----
// Short queue that decouples the front end from the back end.
`default_nettype none

module crrs_fifo #(
    parameter int WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [WIDTH-1:0]   push_data,
    input  logic               pop,
    output logic [WIDTH-1:0]   pop_data,
    output crrs_pkg::q_stat_t  qstat
);
    import crrs_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [Q_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data    = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_W'(Q_DEPTH));
    assign qstat.empty = (count_reg == '0);

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(Q_DEPTH))
        else $error("queue count exceeds its depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg != CNT_W'(Q_DEPTH))
        else $error("transfer into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0 && rd_ptr_reg == $past(rd_ptr_next))
        else $error("pop from an empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/crrs_back.sv -----
// Back end: clears the set memories after reset, then reads, updates and writes back one set's rows per access.
`default_nettype none

module crrs_back #(
    parameter int NUM_SETS  = 2048,
    parameter int NUM_WAYS  = 16,
    parameter int SIG_WIDTH = 6,
    parameter int DUEL_MAX  = 1023,
    localparam int SET_W    = $clog2(NUM_SETS),
    localparam int WAY_W    = $clog2(NUM_WAYS),
    localparam int ENTRY_W  = SET_W + 1 + WAY_W + SIG_WIDTH + crrs_pkg::RND_W
                              + $bits(crrs_pkg::lead_kind_t)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [ENTRY_W-1:0]  pop_data,
    input  crrs_pkg::q_stat_t   qstat,
    output logic                pop,
    output logic                clearing,
    crrs_rsp_if.source          rsp
);
    import crrs_pkg::*;

    localparam int SIG_COUNT = 1 << SIG_WIDTH;
    localparam int DUEL_W    = $clog2(DUEL_MAX + 1);
    localparam int DUEL_MID  = DUEL_MAX / 2;

    typedef struct packed {
        logic [SET_W-1:0]     set_idx;
        logic                 hit;
        logic [WAY_W-1:0]     way;
        logic [SIG_WIDTH-1:0] sig;
        logic [RND_W-1:0]     rnd;
        lead_kind_t           kind;
    } entry_t;

    typedef logic [NUM_WAYS-1:0][AGE_W-1:0]     age_row_t;
    typedef logic [NUM_WAYS-1:0][SIG_WIDTH-1:0] sig_row_t;
    typedef logic [SIG_COUNT-1:0][CTR_W-1:0]    ctr_row_t;

    age_row_t age_mem   [NUM_SETS];
    sig_row_t sig_mem   [NUM_SETS];
    ctr_row_t reuse_mem [NUM_SETS];

    age_row_t age_rd_reg;
    sig_row_t sig_rd_reg;
    ctr_row_t reuse_rd_reg;

    back_state_t          state_reg, state_next;
    logic [SET_W-1:0]     clr_cnt_reg, clr_cnt_next;
    entry_t               cur_reg;
    entry_t               q_ent;
    logic [DUEL_W-1:0]    duel_reg, duel_next;

    logic                 out_valid_reg, out_valid_next;
    logic [WAY_OUT_W-1:0] out_way_reg;
    age_t                 out_age_reg;
    logic                 out_bimodal_reg;

    logic                 slot_free;
    logic                 mem_re;
    logic                 mem_we;
    logic                 item_done;
    logic [SET_W-1:0]     wr_addr;
    age_row_t             age_wr;
    sig_row_t             sig_wr;
    ctr_row_t             reuse_wr;

    age_row_t             age_upd;
    sig_row_t             sig_upd;
    ctr_row_t             reuse_upd;
    logic [WAY_W-1:0]     res_way;
    age_t                 res_age;
    logic                 res_bimodal;
    logic [DUEL_W-1:0]    duel_upd;

    assign q_ent     = pop_data;
    assign slot_free = !out_valid_reg || rsp.ready;

    // Sequencer: next state.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SET_W'(NUM_SETS - 1))
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (!qstat.empty)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (slot_free)
                begin
                    state_next = ST_READ;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb
    begin
        pop       = 1'b0;
        clearing  = 1'b0;
        item_done = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clearing = 1'b1;
            end
            ST_READ:
            begin
                pop = !qstat.empty;
            end
            ST_WRITE:
            begin
                item_done = slot_free;
            end
            default:
            begin
                clearing = 1'b1;
            end
        endcase
    end

    assign mem_re = pop;
    assign mem_we = clearing || item_done;

    always_comb
    begin
        if (clearing)
        begin
            wr_addr  = clr_cnt_reg;
            age_wr   = {NUM_WAYS{AGE_MAX}};
            sig_wr   = '0;
            reuse_wr = {SIG_COUNT{REUSE_INIT}};
        end
        else
        begin
            wr_addr  = cur_reg.set_idx;
            age_wr   = age_upd;
            sig_wr   = sig_upd;
            reuse_wr = reuse_upd;
        end
    end

    // Row update for the item whose set rows sit in the read registers.
    always_comb
    begin
        logic             m1;
        logic             m0;
        age_t             oldest;
        age_t             step;
        logic [WAY_W-1:0] victim;
        logic [SIG_WIDTH-1:0] old_sig;
        ctr_t             cnt;
        logic             dead;

        m1 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            m1 = m1 | age_rd_reg[w][1];
        end
        m0 = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if (age_rd_reg[w][1] == m1)
            begin
                m0 = m0 | age_rd_reg[w][0];
            end
        end
        oldest = {m1, m0};
        step   = AGE_MAX - oldest;
        victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--)
        begin
            if (age_rd_reg[w] == oldest)
            begin
                victim = WAY_W'(w);
            end
        end
        old_sig     = sig_rd_reg[victim];
        duel_upd    = duel_reg;
        sig_upd     = sig_rd_reg;
        reuse_upd   = reuse_rd_reg;
        res_bimodal = 1'b0;
        dead        = 1'b0;

        if (cur_reg.hit)
        begin
            age_upd              = age_rd_reg;
            age_upd[cur_reg.way] = AGE_HIT;
            cnt = reuse_rd_reg[cur_reg.sig];
            if (cnt != REUSE_MAX)
            begin
                reuse_upd[cur_reg.sig] = cnt + 1'b1;
            end
            if (cur_reg.kind == LEAD_SRRIP && duel_reg != DUEL_W'(DUEL_MAX))
            begin
                duel_upd = duel_reg + 1'b1;
            end
            else if (cur_reg.kind == LEAD_BRRIP && duel_reg != '0)
            begin
                duel_upd = duel_reg - 1'b1;
            end
            res_way = cur_reg.way;
            res_age = AGE_HIT;
        end
        else
        begin
            for (int w = 0; w < NUM_WAYS; w++)
            begin
                age_upd[w] = age_rd_reg[w] + step;
            end
            cnt = reuse_rd_reg[old_sig];
            if (cnt != REUSE_DEAD)
            begin
                reuse_upd[old_sig] = cnt - 1'b1;
            end
            dead = (reuse_upd[cur_reg.sig] == REUSE_DEAD);
            if (cur_reg.kind == LEAD_BRRIP)
            begin
                res_bimodal = 1'b1;
            end
            else if (cur_reg.kind == LEAD_SRRIP)
            begin
                res_bimodal = 1'b0;
            end
            else
            begin
                res_bimodal = (duel_reg < DUEL_W'(DUEL_MID));
            end
            if (dead)
            begin
                res_age = AGE_MAX;
            end
            else if (res_bimodal)
            begin
                res_age = (cur_reg.rnd == '0) ? AGE_LONG : AGE_MAX;
            end
            else
            begin
                res_age = AGE_LONG;
            end
            age_upd[victim] = res_age;
            sig_upd[victim] = cur_reg.sig;
            res_way         = victim;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        duel_next      = duel_reg;
        if (item_done)
        begin
            out_valid_next = 1'b1;
            duel_next      = duel_upd;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            duel_reg      <= DUEL_W'(DUEL_MID);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            duel_reg      <= duel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= q_ent;
        end
        if (item_done)
        begin
            out_way_reg     <= WAY_OUT_W'(res_way);
            out_age_reg     <= res_age;
            out_bimodal_reg <= res_bimodal;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            age_mem[wr_addr]   <= age_wr;
            sig_mem[wr_addr]   <= sig_wr;
            reuse_mem[wr_addr] <= reuse_wr;
        end
        if (mem_re)
        begin
            age_rd_reg   <= age_mem[q_ent.set_idx];
            sig_rd_reg   <= sig_mem[q_ent.set_idx];
            reuse_rd_reg <= reuse_mem[q_ent.set_idx];
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.chosen_way   = out_way_reg;
    assign rsp.inserted_age = out_age_reg;
    assign rsp.used_bimodal = out_bimodal_reg;

`ifndef SYNTH
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !out_valid_reg && !pop)
        else $error("result or queue pop during the clearing pass");

    a_pop_then_write: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg == ST_WRITE)
        else $error("row read not followed by the write-back cycle");

    a_result_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_WRITE)
        else $error("result appeared without a write-back");

    a_duel_bound: assert property (@(posedge clk) disable iff (!rst_n)
        duel_reg <= DUEL_W'(DUEL_MAX))
        else $error("duel counter above its maximum");
`endif

endmodule

`default_nettype wire

// ----- rtl/cache_replacement_rrip_ship.sv -----
// Top level of the DRRIP replacement policy with signature-based insertion.
// Each access passes through two back-end states: one reads the set's age, signature
// and reuse-counter rows, the other updates them and writes them back once the result
// register is free; the back end takes the next access only after that write-back.
// After reset a clearing pass writes every set row, with req.ready low.
`default_nettype none

module cache_replacement_rrip_ship #(
    parameter int NUM_SETS     = 2048,
    parameter int NUM_WAYS     = 16,
    parameter int SIG_WIDTH    = 6,
    parameter int LEADER_COUNT = 64,
    parameter int DUEL_MAX     = 1023
) (
    input  logic        clk,
    input  logic        rst_n,
    crrs_req_if.sink    req,
    crrs_rsp_if.source  rsp
);
    import crrs_pkg::*;

    localparam int ENTRY_W = $clog2(NUM_SETS) + 1 + $clog2(NUM_WAYS) + SIG_WIDTH + RND_W
                             + $bits(lead_kind_t);

    logic               push;
    logic               pop;
    logic               clearing;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] pop_data;
    q_stat_t            qstat;

    crrs_front #(
        .NUM_SETS     (NUM_SETS),
        .NUM_WAYS     (NUM_WAYS),
        .SIG_WIDTH    (SIG_WIDTH),
        .LEADER_COUNT (LEADER_COUNT)
    ) u_front (
        .req       (req),
        .clearing  (clearing),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    crrs_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    crrs_back #(
        .NUM_SETS  (NUM_SETS),
        .NUM_WAYS  (NUM_WAYS),
        .SIG_WIDTH (SIG_WIDTH),
        .DUEL_MAX  (DUEL_MAX)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_data),
        .qstat    (qstat),
        .pop      (pop),
        .clearing (clearing),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the RRIP/SHiP replacement policy block.
module tb_top;
    import crrs_pkg::*;

    localparam int NUM_SETS        = 2048;
    localparam int NUM_WAYS        = 16;
    localparam int SIG_COUNT       = 64;
    localparam int LEADER_COUNT    = 64;
    localparam int DUEL_MAX        = 1023;
    localparam int RANDOM_ACCESSES = 1235;
    localparam int SEGMENT_LEN     = 250;
    localparam int IDLE_LIMIT      = 10000;
    localparam int HOLD_CYCLES     = 400;
    localparam int HOLD_AFTER      = 300;
    localparam int DRAIN_CYCLES    = 20;
    localparam int REPORT_LIMIT    = 10;

    typedef struct packed {
        logic [SET_IN_W-1:0] set_index;
        logic                hit;
        logic [WAY_IN_W-1:0] hit_way;
        logic [SIG_IN_W-1:0] signature;
        logic [RND_W-1:0]    random_bits;
    } access_t;

    typedef struct packed {
        logic [WAY_OUT_W-1:0] way;
        age_t                 age;
        logic                 bimodal;
    } choice_t;

    class replacement_tracker;
        age_t                ages[NUM_SETS*NUM_WAYS];
        ctr_t                reuse[NUM_SETS*SIG_COUNT];
        logic [SIG_IN_W-1:0] owner_sig[NUM_SETS*NUM_WAYS];
        int                  duel;
        int                  duel_low;
        int                  duel_high;
        choice_t             expected_choices[$];
        int                  hits;
        int                  misses;
        int                  dead_fills;
        int                  bimodal_fills;
        int                  agings;
        int                  matched;
        int                  mismatches;
        int                  strays;

        function new();
            for (int i = 0; i < NUM_SETS*NUM_WAYS; i++)
            begin
                ages[i] = AGE_MAX;
                owner_sig[i] = '0;
            end
            for (int i = 0; i < NUM_SETS*SIG_COUNT; i++)
            begin
                reuse[i] = REUSE_INIT;
            end
            duel = DUEL_MAX / 2;
            duel_low = duel;
            duel_high = duel;
        endfunction

        function lead_kind_t leader_of(int set_no);
            if (set_no + LEADER_COUNT >= NUM_SETS)
            begin
                return LEAD_BRRIP;
            end
            if (set_no < LEADER_COUNT)
            begin
                return LEAD_SRRIP;
            end
            return LEAD_NONE;
        endfunction

        function void note_access(access_t a);
            int                  set_no;
            int                  row;
            int                  sig_row;
            int                  way;
            int                  oldest;
            int                  victim;
            lead_kind_t          kind;
            logic                bimodal;
            age_t                fill_age;
            logic [SIG_IN_W-1:0] old_sig;
            choice_t             c;
            set_no = a.set_index % NUM_SETS;
            row = set_no * NUM_WAYS;
            sig_row = set_no * SIG_COUNT;
            kind = leader_of(set_no);
            if (a.hit)
            begin
                way = a.hit_way % NUM_WAYS;
                ages[row + way] = AGE_HIT;
                if (reuse[sig_row + a.signature] < REUSE_MAX)
                begin
                    reuse[sig_row + a.signature] = reuse[sig_row + a.signature] + 1'b1;
                end
                if (kind == LEAD_SRRIP && duel < DUEL_MAX)
                begin
                    duel++;
                end
                else if (kind == LEAD_BRRIP && duel > 0)
                begin
                    duel--;
                end
                c.way = WAY_OUT_W'(way);
                c.age = AGE_HIT;
                c.bimodal = 1'b0;
                hits++;
            end
            else
            begin
                oldest = 0;
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (ages[row + w] > oldest)
                    begin
                        oldest = ages[row + w];
                    end
                end
                if (oldest < AGE_MAX)
                begin
                    for (int w = 0; w < NUM_WAYS; w++)
                    begin
                        ages[row + w] = age_t'(ages[row + w] + (AGE_MAX - oldest));
                    end
                    agings++;
                end
                victim = 0;
                for (int w = NUM_WAYS - 1; w >= 0; w--)
                begin
                    if (ages[row + w] == AGE_MAX)
                    begin
                        victim = w;
                    end
                end
                // The evicted block's counter drops before the new signature is looked at.
                old_sig = owner_sig[row + victim];
                if (reuse[sig_row + old_sig] != REUSE_DEAD)
                begin
                    reuse[sig_row + old_sig] = reuse[sig_row + old_sig] - 1'b1;
                end
                bimodal = (kind == LEAD_BRRIP) || (kind == LEAD_NONE && duel < DUEL_MAX / 2);
                if (reuse[sig_row + a.signature] == REUSE_DEAD)
                begin
                    fill_age = AGE_MAX;
                    dead_fills++;
                end
                else if (bimodal)
                begin
                    fill_age = (a.random_bits == 0) ? AGE_LONG : AGE_MAX;
                end
                else
                begin
                    fill_age = AGE_LONG;
                end
                if (bimodal)
                begin
                    bimodal_fills++;
                end
                ages[row + victim] = fill_age;
                owner_sig[row + victim] = a.signature;
                c.way = WAY_OUT_W'(victim);
                c.age = fill_age;
                c.bimodal = bimodal;
                misses++;
            end
            if (duel < duel_low)
            begin
                duel_low = duel;
            end
            if (duel > duel_high)
            begin
                duel_high = duel;
            end
            expected_choices.push_back(c);
        endfunction

        function void check_choice(choice_t got);
            choice_t want;
            if (expected_choices.size() == 0)
            begin
                strays++;
                if (strays + mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: unexpected result way=%0d age=%0d bimodal=%0d", $realtime,
                             got.way, got.age, got.bimodal);
                end
                return;
            end
            want = expected_choices.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (strays + mismatches <= REPORT_LIMIT)
                begin
                    $display("%0t: result mismatch: expected way=%0d age=%0d bimodal=%0d,",
                             $realtime, want.way, want.age, want.bimodal);
                    $display("    got way=%0d age=%0d bimodal=%0d",
                             got.way, got.age, got.bimodal);
                end
            end
            else
            begin
                matched++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    crrs_req_if req_ch ();
    crrs_rsp_if rsp_ch ();

    replacement_tracker sb = new();

    int burst_left = 0;
    int hot_sets[10] = '{0, 5, 63, 64, 700, 1500, 1983, 1984, 2000, 2047};

    cache_replacement_rrip_ship dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    task automatic apply_access(input access_t a);
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
        end
        burst_left--;
        req_ch.set_index <= a.set_index;
        req_ch.hit <= a.hit;
        req_ch.hit_way <= a.hit_way;
        req_ch.signature <= a.signature;
        req_ch.random_bits <= a.random_bits;
        req_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sb.note_access(a);
        @(negedge clk);
    endtask

    task automatic apply_directed(input int set_no, input int hit, input int way,
                                  input int sig, input int rnd);
        access_t a;
        a.set_index = SET_IN_W'(set_no);
        a.hit = (hit != 0);
        a.hit_way = WAY_IN_W'(way);
        a.signature = SIG_IN_W'(sig);
        a.random_bits = RND_W'(rnd);
        apply_access(a);
    endtask

    initial
    begin
        access_t a;
        int      bias;
        int      pick;
        req_ch.valid = 1'b0;
        req_ch.set_index = '0;
        req_ch.hit = 1'b0;
        req_ch.hit_way = '0;
        req_ch.signature = '0;
        req_ch.random_bits = '0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first miss evicts a block whose signature equals the new one.
        apply_directed(0, 0, 0, 0, 1);
        apply_directed(0, 0, 15, 5, 31);
        apply_directed(0, 1, 15, 63, 31);
        apply_directed(0, 1, 1, 5, 0);
        apply_directed(2047, 1, 0, 0, 0);
        apply_directed(2047, 0, 0, 63, 0);
        apply_directed(2047, 0, 9, 63, 31);
        apply_directed(1984, 0, 3, 1, 0);
        apply_directed(1983, 0, 0, 2, 0);
        apply_directed(1983, 0, 0, 2, 17);
        apply_directed(63, 1, 7, 2, 4);
        apply_directed(64, 0, 15, 42, 0);
        apply_directed(1024, 0, 15, 21, 31);
        apply_directed(1024, 1, 8, 21, 1);
        apply_directed(1024, 0, 0, 21, 2);

        // Segments cycle through neutral, pulling the duel counter down, pushing it up and neutral again.
        for (int i = 0; i < RANDOM_ACCESSES; i++)
        begin
            case ((i / SEGMENT_LEN) % 4)
                1:       bias = 2;
                2:       bias = 1;
                default: bias = 0;
            endcase
            a.hit = ($urandom_range(99) < 45);
            pick = $urandom_range(99);
            if (a.hit && bias == 1 && pick < 60)
            begin
                a.set_index = SET_IN_W'($urandom_range(LEADER_COUNT - 1));
            end
            else if (a.hit && bias == 2 && pick < 60)
            begin
                a.set_index = SET_IN_W'(NUM_SETS - 1 - $urandom_range(LEADER_COUNT - 1));
            end
            else if (pick < 80)
            begin
                a.set_index = SET_IN_W'(hot_sets[$urandom_range(9)]);
            end
            else
            begin
                a.set_index = SET_IN_W'($urandom_range(NUM_SETS - 1));
            end
            a.hit_way = WAY_IN_W'($urandom_range(15));
            a.signature = SIG_IN_W'(($urandom_range(3) == 0) ? $urandom_range(63)
                                                             : $urandom_range(7));
            a.random_bits = RND_W'(($urandom_range(4) == 0) ? 0 : $urandom_range(31));
            apply_access(a);
        end
        req_ch.valid <= 1'b0;

        while (sb.expected_choices.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("tb_top: %0d accesses, %0d hits and %0d misses; %0d fills with a dead signature",
                 sb.hits + sb.misses, sb.hits, sb.misses, sb.dead_fills);
        $display("tb_top: %0d bimodal fills, %0d set agings, duel counter spanned %0d to %0d",
                 sb.bimodal_fills, sb.agings, sb.duel_low, sb.duel_high);
        if (sb.mismatches == 0 && sb.strays == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // The receiver follows a rotating stall pattern and holds off once for a long stretch.
    initial
    begin
        int cyc;
        bit held;
        cyc = 0;
        held = 1'b0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (!held && sb.matched + sb.mismatches >= HOLD_AFTER)
            begin
                held = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            case ((cyc / 97) % 4)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= ($urandom_range(9) < 7);
                2:       rsp_ch.ready <= (cyc % 3 != 0);
                default: rsp_ch.ready <= ($urandom_range(9) < 3);
            endcase
        end
    end

    initial
    begin
        choice_t got;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                got.way = rsp_ch.chosen_way;
                got.age = rsp_ch.inserted_age;
                got.bimodal = rsp_ch.used_bimodal;
                sb.check_choice(got);
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: no transfer for %0d cycles", IDLE_LIMIT);
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

endmodule
